@@ rtl/core/rba_pkg.sv @@
// shared types and constants of the register block allocator
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package rba_pkg;
	// field widths
	localparam int LOG2_W = 3;
	localparam int CNT_W = 11;
	localparam int LEN_W = 11;
	localparam int BASE_W = 11;
	localparam int BOUT_W = 10;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// parameter defaults
	localparam int REG_COUNT_DEF = 1024;
	localparam int OWNER_WIDTH_DEF = 8;

	// constants
	localparam logic [LOG2_W-1:0] MAX_LOG2 = 3'd5;
	localparam logic [BASE_W-1:0] NONE_BASE = 11'd1024;

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	// register index codes (paddr bit 2)
	localparam logic REG_INT_LOG2 = 1'b0;
	localparam logic REG_FLT_LOG2 = 1'b1;

	// register type codes
	localparam logic TYP_INT = 1'b0;
	localparam logic TYP_FLT = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_TYPE_FLT,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_COMMIT,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clr_step;
		logic load;
		logic scan_init;
		logic scan_typ;
		logic scan_rd;
		logic scan_ev;
		logic free_wr;
		logic commit;
		logic fail;
		logic out_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic is_free;
		logic int_zero;
		logic flt_zero;
		logic pos_end;
		logic found;
		logic sel;
	} dp_sts_t;
endpackage
`default_nettype wire

@@ rtl/core/rba_dp.sv @@
// datapath of the register block allocator: run length tables, owner tables,
// scan position and result registers; depends on rba_pkg
`timescale 1ns / 1ps
`default_nettype none
module rba_dp #(
	parameter int REG_COUNT = rba_pkg::REG_COUNT_DEF,
	parameter int OWNER_WIDTH = rba_pkg::OWNER_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire rba_pkg::dp_cmd_t ctl,
	output rba_pkg::dp_sts_t sts,
	input wire logic [rba_pkg::LOG2_W-1:0] int_lg,
	input wire logic [rba_pkg::LOG2_W-1:0] flt_lg,
	input wire logic cmd,
	input wire logic [rba_pkg::CNT_W-1:0] int_count,
	input wire logic [rba_pkg::CNT_W-1:0] flt_count,
	input wire logic [OWNER_WIDTH-1:0] owner_id,
	input wire logic [rba_pkg::BASE_W-1:0] int_base_in,
	input wire logic [rba_pkg::BASE_W-1:0] flt_base_in,
	output logic success,
	output logic int_valid,
	output logic [rba_pkg::BOUT_W-1:0] int_base_out,
	output logic flt_valid,
	output logic [rba_pkg::BOUT_W-1:0] flt_base_out
);
	localparam int IDX_W = $clog2(REG_COUNT);
	localparam int POS_W = $clog2(REG_COUNT + (1 << rba_pkg::LEN_W));
	localparam int SH_W = IDX_W + (1 << rba_pkg::LOG2_W);

	// tables
	logic [rba_pkg::LEN_W-1:0] int_len_mem [REG_COUNT];
	logic [rba_pkg::LEN_W-1:0] flt_len_mem [REG_COUNT];
	logic [OWNER_WIDTH-1:0] int_own_mem [REG_COUNT];
	logic [OWNER_WIDTH-1:0] flt_own_mem [REG_COUNT];

	// request registers
	logic cmd_q;
	logic [rba_pkg::CNT_W-1:0] int_cnt_q, flt_cnt_q;
	logic [OWNER_WIDTH-1:0] owner_q;
	logic [rba_pkg::BASE_W-1:0] int_bin_q, flt_bin_q;

	// scan state
	logic sel_q;
	logic [POS_W-1:0] pos_q, first_q;
	logic [rba_pkg::LEN_W-1:0] run_q;
	logic [IDX_W-1:0] int_start_q, flt_start_q, clr_q;
	logic [rba_pkg::LEN_W-1:0] int_rd_q, flt_rd_q;
	logic fail_q;

	logic [rba_pkg::LEN_W-1:0] int_need, flt_need, need_sel, rd_len;
	logic [POS_W-1:0] int_nblk, flt_nblk, nblk_sel, int_blk, flt_blk;
	logic int_free_ok, flt_free_ok, found;
	logic int_we, flt_we;
	logic [IDX_W-1:0] int_wa, flt_wa;
	logic [rba_pkg::LEN_W-1:0] int_wd, flt_wd;
	logic int_ok, flt_ok;
	logic [SH_W-1:0] int_sh, flt_sh;

	// block counts and rounded-up block needs
	always_comb begin
		int_need = rba_pkg::LEN_W'(({1'b0, int_cnt_q} + ((12'd1 << int_lg) - 12'd1)) >> int_lg);
		flt_need = rba_pkg::LEN_W'(({1'b0, flt_cnt_q} + ((12'd1 << flt_lg) - 12'd1)) >> flt_lg);
		int_nblk = POS_W'(REG_COUNT) >> int_lg;
		flt_nblk = POS_W'(REG_COUNT) >> flt_lg;
		need_sel = sel_q ? flt_need : int_need;
		nblk_sel = sel_q ? flt_nblk : int_nblk;
		rd_len = sel_q ? flt_rd_q : int_rd_q;
		found = (rd_len == '0) && (({1'b0, run_q} + 12'd1) == {1'b0, need_sel});
	end

	// free targets
	always_comb begin
		int_blk = POS_W'(int_bin_q) >> int_lg;
		flt_blk = POS_W'(flt_bin_q) >> flt_lg;
		int_free_ok = (int_bin_q != rba_pkg::NONE_BASE) && (int_blk < int_nblk);
		flt_free_ok = (flt_bin_q != rba_pkg::NONE_BASE) && (flt_blk < flt_nblk);
	end

	// table write selection: clear sweep, free, commit
	always_comb begin
		int_we = ctl.clr_step || (ctl.free_wr && int_free_ok) ||
			(ctl.commit && (int_cnt_q != '0));
		flt_we = ctl.clr_step || (ctl.free_wr && flt_free_ok) ||
			(ctl.commit && (flt_cnt_q != '0));
		int_wa = ctl.clr_step ? clr_q : (ctl.free_wr ? int_blk[IDX_W-1:0] : int_start_q);
		flt_wa = ctl.clr_step ? clr_q : (ctl.free_wr ? flt_blk[IDX_W-1:0] : flt_start_q);
		int_wd = ctl.commit ? int_need : '0;
		flt_wd = ctl.commit ? flt_need : '0;
	end

	// integer tables
	always_ff @(posedge clk) begin
		if (int_we) begin
			int_len_mem[int_wa] <= int_wd;
		end
		if (ctl.commit && (int_cnt_q != '0)) begin
			int_own_mem[int_start_q] <= owner_q;
		end
		if (ctl.scan_rd) begin
			int_rd_q <= int_len_mem[pos_q[IDX_W-1:0]];
		end
	end

	// float tables
	always_ff @(posedge clk) begin
		if (flt_we) begin
			flt_len_mem[flt_wa] <= flt_wd;
		end
		if (ctl.commit && (flt_cnt_q != '0)) begin
			flt_own_mem[flt_start_q] <= owner_q;
		end
		if (ctl.scan_rd) begin
			flt_rd_q <= flt_len_mem[pos_q[IDX_W-1:0]];
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			int_cnt_q <= int_count;
			flt_cnt_q <= flt_count;
			owner_q <= owner_id;
			int_bin_q <= int_base_in;
			flt_bin_q <= flt_base_in;
		end
	end

	// clear sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.clr_step) begin
			clr_q <= clr_q + IDX_W'(1);
		end
	end

	// first-fit scan
	always_ff @(posedge clk) begin
		if (ctl.scan_init) begin
			sel_q <= ctl.scan_typ;
			pos_q <= '0;
			run_q <= '0;
		end else if (ctl.scan_ev) begin
			if (rd_len != '0) begin
				pos_q <= pos_q + POS_W'(rd_len);
				run_q <= '0;
			end else begin
				if (run_q == '0) begin
					first_q <= pos_q;
				end
				run_q <= run_q + rba_pkg::LEN_W'(1);
				pos_q <= pos_q + POS_W'(1);
				if (found && (sel_q == rba_pkg::TYP_INT)) begin
					int_start_q <= (run_q == '0) ? pos_q[IDX_W-1:0] : first_q[IDX_W-1:0];
				end
				if (found && (sel_q == rba_pkg::TYP_FLT)) begin
					flt_start_q <= (run_q == '0) ? pos_q[IDX_W-1:0] : first_q[IDX_W-1:0];
				end
			end
		end
	end

	// failure flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_q <= 1'b0;
		end else if (ctl.load) begin
			fail_q <= 1'b0;
		end else if (ctl.fail) begin
			fail_q <= 1'b1;
		end
	end

	// result forming
	always_comb begin
		int_ok = (cmd_q == rba_pkg::CMD_ALLOC) && !fail_q && (int_cnt_q != '0);
		flt_ok = (cmd_q == rba_pkg::CMD_ALLOC) && !fail_q && (flt_cnt_q != '0);
		int_sh = SH_W'(int_start_q) << int_lg;
		flt_sh = SH_W'(flt_start_q) << flt_lg;
	end

	// result registers
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			success <= !fail_q;
			int_valid <= int_ok;
			flt_valid <= flt_ok;
			int_base_out <= int_ok ? rba_pkg::BOUT_W'(int_sh) : '0;
			flt_base_out <= flt_ok ? rba_pkg::BOUT_W'(flt_sh) : '0;
		end
	end

	// status
	always_comb begin
		sts.clr_last = (clr_q == IDX_W'(REG_COUNT - 1));
		sts.is_free = (cmd_q == rba_pkg::CMD_FREE);
		sts.int_zero = (int_cnt_q == '0);
		sts.flt_zero = (flt_cnt_q == '0);
		sts.pos_end = (pos_q >= nblk_sel);
		sts.found = found;
		sts.sel = sel_q;
	end
endmodule
`default_nettype wire

@@ rtl/core/rba_ctrl.sv @@
// controller of the register block allocator: sequencing of clear sweep,
// scans, commit and result handshake; depends on rba_pkg
`timescale 1ns / 1ps
`default_nettype none
module rba_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire rba_pkg::dp_sts_t sts,
	output rba_pkg::dp_cmd_t ctl
);
	rba_pkg::state_t state_q, state_d;
	logic out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rba_pkg::ST_CLEAR: begin
				if (sts.clr_last) state_d = rba_pkg::ST_IDLE;
			end
			rba_pkg::ST_IDLE: begin
				if (in_valid) state_d = rba_pkg::ST_DISPATCH;
			end
			rba_pkg::ST_DISPATCH: begin
				if (sts.is_free) state_d = rba_pkg::ST_FINISH;
				else if (sts.int_zero) state_d = rba_pkg::ST_TYPE_FLT;
				else state_d = rba_pkg::ST_SCAN_RD;
			end
			rba_pkg::ST_TYPE_FLT: begin
				if (sts.flt_zero) state_d = rba_pkg::ST_COMMIT;
				else state_d = rba_pkg::ST_SCAN_RD;
			end
			rba_pkg::ST_SCAN_RD: begin
				if (sts.pos_end) state_d = rba_pkg::ST_FINISH;
				else state_d = rba_pkg::ST_SCAN_EV;
			end
			rba_pkg::ST_SCAN_EV: begin
				if (!sts.found) state_d = rba_pkg::ST_SCAN_RD;
				else if (sts.sel == rba_pkg::TYP_INT) state_d = rba_pkg::ST_TYPE_FLT;
				else state_d = rba_pkg::ST_COMMIT;
			end
			rba_pkg::ST_COMMIT: begin
				state_d = rba_pkg::ST_FINISH;
			end
			rba_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) state_d = rba_pkg::ST_IDLE;
			end
			default: begin
				state_d = rba_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		ctl = '0;
		in_ready = 1'b0;
		case (state_q)
			rba_pkg::ST_CLEAR: begin
				ctl.clr_step = 1'b1;
			end
			rba_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				ctl.load = in_valid;
			end
			rba_pkg::ST_DISPATCH: begin
				ctl.free_wr = sts.is_free;
				ctl.scan_init = !sts.is_free && !sts.int_zero;
				ctl.scan_typ = rba_pkg::TYP_INT;
			end
			rba_pkg::ST_TYPE_FLT: begin
				ctl.scan_init = !sts.flt_zero;
				ctl.scan_typ = rba_pkg::TYP_FLT;
			end
			rba_pkg::ST_SCAN_RD: begin
				ctl.fail = sts.pos_end;
				ctl.scan_rd = !sts.pos_end;
			end
			rba_pkg::ST_SCAN_EV: begin
				ctl.scan_ev = 1'b1;
			end
			rba_pkg::ST_COMMIT: begin
				ctl.commit = 1'b1;
			end
			rba_pkg::ST_FINISH: begin
				ctl.out_load = !out_valid_q || out_ready;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rba_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// no request is taken during the clear sweep
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rba_pkg::ST_CLEAR) |-> !in_ready)
		else $error("request taken during clear sweep");

	// a result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten");

	// commit always leads to the result stage
	a_commit_finish: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> (state_q == rba_pkg::ST_FINISH))
		else $error("commit not followed by result");

	// a table read is only issued inside the block range
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan_rd |-> !sts.pos_end)
		else $error("scan read beyond block count");
endmodule
`default_nettype wire

@@ rtl/core/register_block_allocator.sv @@
// top level of the register block allocator: configuration registers and
// controller/datapath hookup; depends on rba_pkg, rba_ctrl, rba_dp
//
// channel   signals                         direction
// cfg       psel penable pwrite paddr ...   write/read block log2 registers
// request   in_valid in_ready + fields      allocate or free command
// result    out_valid out_ready + fields    one result per request
//
// after reset a clear sweep zeroes every entry of the run length tables;
// no request is taken until it ends, configuration writes are taken always
// a free zeroes its run length entries on dispatch and then loads the result;
// an allocate scans first-fit, a read and an evaluate state per table entry or
// allocated run visited in the integer and then the float table, one read port each
// a new request is taken while the previous result waits in the output register;
// the result stage holds while a previous result still waits and out_ready is low
`timescale 1ns / 1ps
`default_nettype none
module register_block_allocator #(
	parameter int REG_COUNT = rba_pkg::REG_COUNT_DEF,
	parameter int OWNER_WIDTH = rba_pkg::OWNER_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [rba_pkg::ADDR_W-1:0] paddr,
	input wire logic [rba_pkg::DATA_W-1:0] pwdata,
	output logic [rba_pkg::DATA_W-1:0] prdata,
	output logic pready,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic cmd,
	input wire logic [rba_pkg::CNT_W-1:0] int_count,
	input wire logic [rba_pkg::CNT_W-1:0] flt_count,
	input wire logic [OWNER_WIDTH-1:0] owner_id,
	input wire logic [rba_pkg::BASE_W-1:0] int_base_in,
	input wire logic [rba_pkg::BASE_W-1:0] flt_base_in,
	output logic out_valid,
	input wire logic out_ready,
	output logic success,
	output logic int_valid,
	output logic [rba_pkg::BOUT_W-1:0] int_base_out,
	output logic flt_valid,
	output logic [rba_pkg::BOUT_W-1:0] flt_base_out
);
	logic [rba_pkg::LOG2_W-1:0] int_lg_q, flt_lg_q, int_lg, flt_lg;
	logic cfg_wr;
	rba_pkg::dp_cmd_t ctl;
	rba_pkg::dp_sts_t sts;

	// configuration registers
	assign cfg_wr = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_lg_q <= rba_pkg::MAX_LOG2;
			flt_lg_q <= rba_pkg::MAX_LOG2;
		end else if (cfg_wr) begin
			if (paddr[2] == rba_pkg::REG_INT_LOG2) int_lg_q <= pwdata[rba_pkg::LOG2_W-1:0];
			if (paddr[2] == rba_pkg::REG_FLT_LOG2) flt_lg_q <= pwdata[rba_pkg::LOG2_W-1:0];
		end
	end

	// read back and effective block size
	always_comb begin
		pready = 1'b1;
		prdata = (paddr[2] == rba_pkg::REG_FLT_LOG2) ?
			rba_pkg::DATA_W'(flt_lg_q) : rba_pkg::DATA_W'(int_lg_q);
		int_lg = (int_lg_q > rba_pkg::MAX_LOG2) ? rba_pkg::MAX_LOG2 : int_lg_q;
		flt_lg = (flt_lg_q > rba_pkg::MAX_LOG2) ? rba_pkg::MAX_LOG2 : flt_lg_q;
	end

	rba_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts(sts),
		.ctl(ctl)
	);

	rba_dp #(
		.REG_COUNT(REG_COUNT),
		.OWNER_WIDTH(OWNER_WIDTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.sts(sts),
		.int_lg(int_lg),
		.flt_lg(flt_lg),
		.cmd(cmd),
		.int_count(int_count),
		.flt_count(flt_count),
		.owner_id(owner_id),
		.int_base_in(int_base_in),
		.flt_base_in(flt_base_in),
		.success(success),
		.int_valid(int_valid),
		.int_base_out(int_base_out),
		.flt_valid(flt_valid),
		.flt_base_out(flt_base_out)
	);
endmodule
`default_nettype wire
